// ===== hdl/tsd_pkg.sv =====
// Shared types and constants for the telemetry sync-word deframer.
`timescale 1ns / 1ps

package tsd_pkg;

  // Pixels in one line scan, 1 to 128.
  localparam int PIXELS = 128;

  // Byte counter of the line scan: covers 2 * PIXELS bytes.
  localparam int BC_W = (2 * PIXELS > 1) ? $clog2(2 * PIXELS) : 1;
  localparam logic [BC_W-1:0] BC_LAST = BC_W'(2 * PIXELS - 1);

  localparam logic [7:0] SYNC_WORD [4] = '{8'hDE, 8'hAD, 8'hBE, 8'hEF};
  localparam logic [1:0] SYNC_LAST = 2'd3;
  localparam logic [1:0] WORD_LAST = 2'd3;

  // Result queue between parser and output stage.
  localparam int QPTR_W = 1;
  localparam int QUEUE_DEPTH = 2 ** QPTR_W;

  typedef enum logic [1:0] {
    KIND_PIXEL = 2'd0,
    KIND_SERVO = 2'd1,
    KIND_ENC   = 2'd2
  } item_kind_t;

  typedef struct packed {
    item_kind_t  kind;
    logic [6:0]  index;
    logic [31:0] value;
    logic        done;
  } item_t;

endpackage

// ===== hdl/tsd_front.sv =====
// Front end: sync matcher and frame parser, one byte per accepted transfer.
`timescale 1ns / 1ps

module tsd_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    byte_in,
  output logic          push_valid,
  input  logic          push_ready,
  output tsd_pkg::item_t push_item
);
  import tsd_pkg::*;

  typedef enum logic [1:0] {
    PH_INIT  = 2'd0,
    PH_LINE  = 2'd1,
    PH_SERVO = 2'd2,
    PH_ENC   = 2'd3
  } phase_t;

  phase_t          phase, phase_next;
  logic [1:0]      sync_progress, sync_progress_next;
  logic [BC_W-1:0] byte_count, byte_count_next;
  logic [7:0]      pixel_low, pixel_low_next;
  logic [23:0]     word_bytes, word_bytes_next;
  logic [1:0]      word_count, word_count_next;

  logic accept;
  logic match;
  logic sync_hit;

  assign in_ready = push_ready;
  assign accept   = in_valid && in_ready;
  assign match    = byte_in == SYNC_WORD[sync_progress];
  assign sync_hit = match && (sync_progress == SYNC_LAST);

  always_comb begin
    phase_next         = phase;
    sync_progress_next = sync_progress;
    byte_count_next    = byte_count;
    pixel_low_next     = pixel_low;
    word_bytes_next    = word_bytes;
    word_count_next    = word_count;
    push_valid         = 1'b0;
    push_item.kind     = KIND_PIXEL;
    push_item.index    = 7'(byte_count >> 1);
    push_item.value    = 32'({byte_in[3:0], pixel_low});
    push_item.done     = byte_count == BC_LAST;
    if (accept) begin
      // a mismatching byte drops progress without being rechecked as a first byte
      sync_progress_next = match ? 2'(sync_progress + 2'd1) : 2'd0;
      if (sync_hit || phase == PH_INIT) begin
        // swallow this byte and restart the frame
        sync_progress_next = 2'd0;
        byte_count_next    = '0;
        pixel_low_next     = 8'd0;
        word_bytes_next    = 24'd0;
        word_count_next    = 2'd0;
        phase_next         = PH_LINE;
      end else begin
        case (phase)
          PH_LINE: begin
            if (!byte_count[0]) begin
              pixel_low_next = byte_in;
            end else begin
              push_valid = 1'b1;
            end
            byte_count_next = BC_W'(byte_count + 1'b1);
            if (byte_count == BC_LAST) begin
              byte_count_next = '0;
              pixel_low_next  = 8'd0;
              phase_next      = PH_SERVO;
            end
          end
          default: begin
            if (word_count != WORD_LAST) begin
              word_bytes_next = word_bytes | (24'(byte_in) << {word_count, 3'b000});
              word_count_next = 2'(word_count + 2'd1);
            end else begin
              push_valid      = 1'b1;
              push_item.kind  = (phase == PH_SERVO) ? KIND_SERVO : KIND_ENC;
              push_item.index = 7'd0;
              push_item.value = {byte_in, word_bytes};
              push_item.done  = 1'b0;
              word_bytes_next = 24'd0;
              word_count_next = 2'd0;
              phase_next      = PH_ENC;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_INIT;
      sync_progress <= 2'd0;
      byte_count    <= '0;
      pixel_low     <= 8'd0;
      word_bytes    <= 24'd0;
      word_count    <= 2'd0;
    end else begin
      phase         <= phase_next;
      sync_progress <= sync_progress_next;
      byte_count    <= byte_count_next;
      pixel_low     <= pixel_low_next;
      word_bytes    <= word_bytes_next;
      word_count    <= word_count_next;
    end
  end

endmodule

// ===== hdl/tsd_queue.sv =====
// Short result queue between the parser and the output stage.
`timescale 1ns / 1ps

module tsd_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  tsd_pkg::item_t push_item,
  output logic           pop_valid,
  input  logic           pop_ready,
  output tsd_pkg::item_t pop_item
);
  import tsd_pkg::*;

  item_t             slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = count != (QPTR_W + 1)'(QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_item   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= QPTR_W'(wr_ptr + 1'b1);
      end
      if (do_pop) begin
        rd_ptr <= QPTR_W'(rd_ptr + 1'b1);
      end
      if (do_push && !do_pop) begin
        count <= (QPTR_W + 1)'(count + 1'b1);
      end else if (do_pop && !do_push) begin
        count <= (QPTR_W + 1)'(count - 1'b1);
      end
    end
  end

endmodule

// ===== hdl/tsd_back.sv =====
// Back end: output register that presents one result word at a time.
`timescale 1ns / 1ps

module tsd_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           pop_valid,
  output logic           pop_ready,
  input  tsd_pkg::item_t pop_item,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [1:0]     item_kind,
  output logic [6:0]     pixel_index,
  output logic [31:0]    item_value,
  output logic           line_done
);
  import tsd_pkg::*;

  item_t held;

  // refill whenever the register is empty or being drained
  assign pop_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (pop_ready && pop_valid) begin
      held <= pop_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop_ready) begin
      out_valid <= pop_valid;
    end
  end

  assign item_kind   = held.kind;
  assign pixel_index = held.index;
  assign item_value  = held.value;
  assign line_done   = held.done;

endmodule

// ===== hdl/telemetry_sync_deframer.sv =====
// Top level of the telemetry sync-word deframer.
//
//   channel | signals                                      | moves
//   --------+----------------------------------------------+-----------------------
//   in      | in_valid, in_ready, byte_in                  | one received byte
//   out     | out_valid, out_ready, item_kind, pixel_index, | one pixel or 32-bit word
//           | item_value, line_done                        |
//
// One input byte is taken every cycle while in_ready is high; the parser resolves it in that cycle.
// A result passes through the result queue and then the output register before it is valid at the outputs,
// and it waits there longer only while out_ready holds earlier results back.
// in_ready drops only when the two-entry result queue is full.
// Synchronous reset returns the frame to its init phase and empties the queue.
`timescale 1ns / 1ps

module telemetry_sync_deframer (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  byte_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  item_kind,
  output logic [6:0]  pixel_index,
  output logic [31:0] item_value,
  output logic        line_done
);
  import tsd_pkg::*;

  logic  push_valid;
  logic  push_ready;
  item_t push_item;
  logic  pop_valid;
  logic  pop_ready;
  item_t pop_item;

  tsd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .byte_in    (byte_in),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  tsd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  tsd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .pop_valid   (pop_valid),
    .pop_ready   (pop_ready),
    .pop_item    (pop_item),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .item_kind   (item_kind),
    .pixel_index (pixel_index),
    .item_value  (item_value),
    .line_done   (line_done)
  );

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for the telemetry sync-word deframer.
`timescale 1ns / 1ps

module tb_top;
  import tsd_pkg::*;

  localparam int LINE_BYTES = 2 * PIXELS;
  localparam logic [31:0] SYNC_SEQ = 32'hDEADBEEF;
  localparam int STIM_BYTES = 1200;
  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 10;
  localparam int MAX_REPORTS = 200;

  typedef enum logic [1:0] {PH_INIT, PH_LINE, PH_SERVO, PH_ENC} frame_phase_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  byte_in = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  item_kind;
  logic [6:0]  pixel_index;
  logic [31:0] item_value;
  logic        line_done;

  telemetry_sync_deframer u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .byte_in     (byte_in),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .item_kind   (item_kind),
    .pixel_index (pixel_index),
    .item_value  (item_value),
    .line_done   (line_done)
  );

  always #5 clk = ~clk;

  logic [7:0] byte_queue[$];
  item_t      expected_items[$];
  logic       byte_taken = 1'b0;
  int         err_count = 0;
  int         idle_cycles = 0;
  int         gap_left = 0;
  int         burst_left = 0;
  int         stall_tick = 0;

  // Deframer state mirror
  frame_phase_t phase_m = PH_INIT;
  int unsigned  sync_cnt = 0;
  int unsigned  line_bytes = 0;
  int unsigned  word_len = 0;
  logic [7:0]   low_byte = 8'h00;
  logic [23:0]  word_acc = 24'h0;

  task automatic deframe_byte(input logic [7:0] b);
    item_t it;
    if (sync_cnt < 4 && b == SYNC_SEQ[31 - 8 * sync_cnt -: 8]) sync_cnt++;
    else sync_cnt = 0;
    if (sync_cnt == 4) phase_m = PH_INIT;
    case (phase_m)
      PH_INIT: begin
        // swallow the byte and restart the frame
        line_bytes = 0;
        sync_cnt = 0;
        low_byte = 8'h00;
        word_acc = 24'h0;
        word_len = 0;
        phase_m = PH_LINE;
      end
      PH_LINE: begin
        if (line_bytes[0] == 1'b0) begin
          low_byte = b;
        end else begin
          it.kind = KIND_PIXEL;
          it.index = 7'(line_bytes >> 1);
          it.value = {20'd0, b[3:0], low_byte};
          it.done = ((line_bytes >> 1) + 1 >= PIXELS);
          expected_items.push_back(it);
        end
        line_bytes++;
        if (line_bytes >= LINE_BYTES) begin
          line_bytes = 0;
          low_byte = 8'h00;
          phase_m = PH_SERVO;
        end
      end
      default: begin
        if (word_len < 3) begin
          word_acc[8 * word_len +: 8] = b;
          word_len++;
        end else begin
          it.kind = (phase_m == PH_SERVO) ? KIND_SERVO : KIND_ENC;
          it.index = 7'd0;
          it.value = {b, word_acc};
          it.done = 1'b0;
          expected_items.push_back(it);
          word_acc = 24'h0;
          word_len = 0;
          phase_m = PH_ENC;
        end
      end
    endcase
  endtask

  task automatic flag_mismatch(input string field, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      err_count++;
      if (err_count <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    end
  endtask

  // Sender: bursts of random length separated by random gaps
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || byte_taken) begin
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left--;
      end else if (byte_queue.size() > 0) begin
        in_valid <= 1'b1;
        byte_in <= byte_queue.pop_front();
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: out_ready follows four stall styles in turn
  always @(negedge clk) begin
    stall_tick++;
    case ((stall_tick / 200) % 4)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      2: out_ready <= ((stall_tick % 16) >= 8);
      default: out_ready <= 1'($urandom_range(0, 1));
    endcase
  end

  // Check results, mirror accepted bytes, watch for a hang
  always @(posedge clk) begin
    item_t want;
    if (rst) begin
      byte_taken <= 1'b0;
      idle_cycles = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_items.size() == 0) begin
          err_count++;
          if (err_count <= MAX_REPORTS)
            $display("%0t: extra result, expected none, actual %0d/%0d/%0h/%0b",
                     $time, item_kind, pixel_index, item_value, line_done);
        end else begin
          want = expected_items.pop_front();
          flag_mismatch("item_kind", 32'(want.kind), 32'(item_kind));
          flag_mismatch("pixel_index", 32'(want.index), 32'(pixel_index));
          flag_mismatch("item_value", want.value, item_value);
          flag_mismatch("line_done", 32'(want.done), 32'(line_done));
        end
      end
      if (in_valid && in_ready) deframe_byte(byte_in);
      byte_taken <= in_valid && in_ready;
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic push_bytes(input int count);
    repeat (count) byte_queue.push_back(pick_byte());
  endtask

  task automatic push_sync(input int len);
    for (int k = 0; k < len; k++) byte_queue.push_back(SYNC_SEQ[31 - 8 * k -: 8]);
  endtask

  initial begin
    int sel;
    // Directed: discarded first byte, failed and good sync, pixel extremes,
    // sync bytes taken as pixel data
    byte_queue = '{8'h00,
                   8'hDE, 8'hDE, 8'hAD, 8'hBE, 8'hEF,
                   8'hDE, 8'hAD, 8'hBE, 8'hEF,
                   8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'h0F, 8'h00, 8'hF0,
                   8'h34, 8'hA2, 8'hDE, 8'hAD, 8'hBE, 8'h55};
    while (byte_queue.size() < STIM_BYTES) begin
      sel = $urandom_range(0, 9);
      if (sel <= 6) begin
        push_sync(4);
        push_bytes(LINE_BYTES);
        push_bytes(4 + 4 * $urandom_range(0, 6));
      end else if (sel == 7) begin
        // partial sync broken by a stray byte
        push_sync($urandom_range(1, 3));
        push_bytes($urandom_range(1, 8));
      end else if (sel == 8) begin
        push_sync(4);
        push_bytes($urandom_range(1, LINE_BYTES - 1));
      end else begin
        push_bytes($urandom_range(1, 40));
      end
    end
    // trim the tail of the last frame
    while (byte_queue.size() > STIM_BYTES) void'(byte_queue.pop_back());
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    while (byte_queue.size() != 0 || in_valid || expected_items.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (err_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
